// ===== src/usage_limit_watchdog_top_assert.svh =====
// Assertion macros for the usage limit watchdog.
// Each macro expects clk and rst_n in scope.
`ifndef USAGE_LIMIT_WATCHDOG_TOP_ASSERT_SVH
`define USAGE_LIMIT_WATCHDOG_TOP_ASSERT_SVH

// Same-cycle implication.
`define UWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/uwd_pkg.sv =====
`default_nettype none

package uwd_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STREAK_W = 16;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned ADDR_W   = 4;

  // outcome codes
  localparam logic [CODE_W-1:0] OUT_OK        = 3'd0;
  localparam logic [CODE_W-1:0] OUT_SKIPPED   = 3'd1;
  localparam logic [CODE_W-1:0] OUT_VIOLATION = 3'd2;
  localparam logic [CODE_W-1:0] OUT_CRITICAL  = 3'd3;
  localparam logic [CODE_W-1:0] OUT_ERROR     = 3'd4;

  // monitor modes
  localparam logic [CODE_W-1:0] MODE_IDLE       = 3'd0;
  localparam logic [CODE_W-1:0] MODE_OK         = 3'd1;
  localparam logic [CODE_W-1:0] MODE_VIOLATION  = 3'd2;
  localparam logic [CODE_W-1:0] MODE_CRITICAL   = 3'd3;
  localparam logic [CODE_W-1:0] MODE_RECOVERING = 3'd4;
  localparam logic [CODE_W-1:0] MODE_ERROR      = 3'd5;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_RES_LIM  = 2'd1;
  localparam logic [1:0] REG_VIRT_LIM = 2'd2;
  localparam logic [1:0] REG_CRIT     = 2'd3;

endpackage

`default_nettype wire

// ===== src/uwd_in_if.sv =====
`default_nettype none

interface uwd_in_if import uwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] time_ms;
  logic [DATA_W-1:0] resident_kb;
  logic [DATA_W-1:0] virtual_kb;
  logic              read_failed;

  modport source (output valid, time_ms, resident_kb, virtual_kb, read_failed,
                  input ready);
  modport sink (input valid, time_ms, resident_kb, virtual_kb, read_failed,
                output ready);
endinterface

`default_nettype wire

// ===== src/uwd_out_if.sv =====
`default_nettype none

interface uwd_out_if import uwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] outcome;
  logic [CODE_W-1:0] monitor_state;
  logic [DATA_W-1:0] total_violations;
  logic [DATA_W-1:0] streak_violations;
  logic              violation_event;
  logic              critical_event;

  modport source (output valid, outcome, monitor_state, total_violations,
                  streak_violations, violation_event, critical_event,
                  input ready);
  modport sink (input valid, outcome, monitor_state, total_violations,
                streak_violations, violation_event, critical_event,
                output ready);
endinterface

`default_nettype wire

// ===== src/usage_limit_watchdog_top.sv =====
// Channel  | Dir | Handshake      | Payload
// ---------+-----+----------------+------------------------------------------------
// in_ch    | in  | valid/ready    | time_ms, resident_kb, virtual_kb, read_failed
// out_ch   | out | valid/ready    | outcome, monitor_state, total/streak counts, events
// APB      | in  | psel/penable   | 4 x 32-bit regs at bytes 0,4,8,12; crit is 16-bit
//
// One sample per cycle sustained while out_ch takes results; each sample passes
// through the input register, then the result register, and out_ch.valid rises
// when the sample loads the result register.
// The state update is one compare/subtract/increment pass between the two registers.
// Synchronous active-low rst_n clears config, valid flags, counters and monitor state.
// A stalled out_ch holds the result and backs up into the input register; in_ch
// stays ready as long as the input register is empty or moving forward.
`default_nettype none

`include "usage_limit_watchdog_top_assert.svh"

module usage_limit_watchdog_top import uwd_pkg::*; (
  input  wire              clk,
  input  wire              rst_n,
  uwd_in_if.sink           in_ch,
  uwd_out_if.source        out_ch,
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire [ADDR_W-1:0] paddr,
  input  wire [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic             pready
);

  localparam logic [DATA_W-1:0] SAT_MAX = '1;

  // configuration
  logic [DATA_W-1:0]   interval_r;
  logic [DATA_W-1:0]   res_lim_r;
  logic [DATA_W-1:0]   virt_lim_r;
  logic [STREAK_W-1:0] crit_r;

  // monitor state
  logic [DATA_W-1:0] last_r, last_nxt;
  logic [DATA_W-1:0] total_r, total_nxt;
  logic [DATA_W-1:0] streak_r, streak_nxt;
  logic [CODE_W-1:0] mode_r, mode_nxt;

  // input register
  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_time_r;
  logic [DATA_W-1:0] s1_res_r;
  logic [DATA_W-1:0] s1_virt_r;
  logic              s1_fail_r;

  // result register
  logic              out_valid_r;
  logic [CODE_W-1:0] outcome_r, outcome_nxt;
  logic              vev_r, vev_nxt;
  logic              cev_r, cev_nxt;
  logic [CODE_W-1:0] mode_out_r;
  logic [DATA_W-1:0] total_out_r;
  logic [DATA_W-1:0] streak_out_r;

  logic              out_load;
  logic              adv;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  logic [DATA_W-1:0] elapsed;
  logic              skip;
  logic              breach;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, write lands on the access phase.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= '0;
      res_lim_r  <= '0;
      virt_lim_r <= '0;
      crit_r     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INTERVAL: interval_r <= pwdata;
        REG_RES_LIM:  res_lim_r  <= pwdata;
        REG_VIRT_LIM: virt_lim_r <= pwdata;
        REG_CRIT:     crit_r     <= pwdata[STREAK_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INTERVAL: prdata = interval_r;
      REG_RES_LIM:  prdata = res_lim_r;
      REG_VIRT_LIM: prdata = virt_lim_r;
      REG_CRIT:     prdata = {{(DATA_W-STREAK_W){1'b0}}, crit_r};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: result register loads when empty or being drained; the input
  // register advances into it, and a new transfer refills the input register.
  // ---------------------------------------------------------------------------
  assign out_load    = !out_valid_r || out_ch.ready;
  assign adv         = s1_valid_r && out_load;
  assign in_ch.ready = !s1_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_time_r <= in_ch.time_ms;
      s1_res_r  <= in_ch.resident_kb;
      s1_virt_r <= in_ch.virtual_kb;
      s1_fail_r <= in_ch.read_failed;
    end
  end

  // ---------------------------------------------------------------------------
  // Check logic. Elapsed time wraps mod 2^32; a stored time of zero means the
  // monitor has never checked, so nothing is skipped.
  // ---------------------------------------------------------------------------
  assign elapsed = s1_time_r - last_r;
  assign skip    = (last_r != '0) && (elapsed < interval_r);
  assign breach  = ((res_lim_r != '0) && (s1_res_r > res_lim_r)) ||
                   ((virt_lim_r != '0) && (s1_virt_r > virt_lim_r));

  always_comb begin
    last_nxt    = last_r;
    total_nxt   = total_r;
    streak_nxt  = streak_r;
    mode_nxt    = mode_r;
    outcome_nxt = OUT_SKIPPED;
    vev_nxt     = 1'b0;
    cev_nxt     = 1'b0;
    priority if (skip) begin
      outcome_nxt = OUT_SKIPPED;
    end else if (s1_fail_r) begin
      last_nxt    = s1_time_r;
      mode_nxt    = MODE_ERROR;
      outcome_nxt = OUT_ERROR;
    end else if (breach) begin
      last_nxt   = s1_time_r;
      total_nxt  = (total_r == SAT_MAX) ? total_r : total_r + 1'b1;
      streak_nxt = (streak_r == SAT_MAX) ? streak_r : streak_r + 1'b1;
      vev_nxt    = 1'b1;
      if ((crit_r != '0) &&
          (streak_nxt >= {{(DATA_W-STREAK_W){1'b0}}, crit_r})) begin
        mode_nxt    = MODE_CRITICAL;
        outcome_nxt = OUT_CRITICAL;
        cev_nxt     = 1'b1;
      end else begin
        mode_nxt    = MODE_VIOLATION;
        outcome_nxt = OUT_VIOLATION;
      end
    end else begin
      // clean sample ends the streak
      last_nxt    = s1_time_r;
      streak_nxt  = '0;
      mode_nxt    = ((mode_r == MODE_VIOLATION) || (mode_r == MODE_CRITICAL)) ?
                    MODE_RECOVERING : MODE_OK;
      outcome_nxt = OUT_OK;
    end
  end

  // State commits only when the sample moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      total_r  <= '0;
      streak_r <= '0;
      mode_r   <= MODE_IDLE;
    end else if (adv) begin
      last_r   <= last_nxt;
      total_r  <= total_nxt;
      streak_r <= streak_nxt;
      mode_r   <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outcome_r    <= outcome_nxt;
      mode_out_r   <= mode_nxt;
      total_out_r  <= total_nxt;
      streak_out_r <= streak_nxt;
      vev_r        <= vev_nxt;
      cev_r        <= cev_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.outcome           = outcome_r;
  assign out_ch.monitor_state     = mode_out_r;
  assign out_ch.total_violations  = total_out_r;
  assign out_ch.streak_violations = streak_out_r;
  assign out_ch.violation_event   = vev_r;
  assign out_ch.critical_event    = cev_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `UWD_ASSERT_NOW(a_streak_le_total, 1'b1, streak_r <= total_r,
                  "violation streak exceeds total")
  `UWD_ASSERT_NEXT(a_state_holds, !adv,
                   $stable(total_r) && $stable(streak_r) && $stable(last_r),
                   "monitor state changed without a sample")
  `UWD_ASSERT_NOW(a_crit_implies_viol, out_valid_r && cev_r,
                  vev_r && (outcome_r == OUT_CRITICAL) && (mode_out_r == MODE_CRITICAL),
                  "critical event without matching violation result")

endmodule

`default_nettype wire
